@@ rtl/minimum_spanning_tree_cost_top_macros.svh @@
// Assertion macros for the minimum spanning tree cost block.
`ifndef MINIMUM_SPANNING_TREE_COST_TOP_MACROS_SVH
`define MINIMUM_SPANNING_TREE_COST_TOP_MACROS_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define MSTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert that an antecedent implies a consequent in the following cycle.
`define MSTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mstc_pkg.sv @@
// Shared constants and types for the minimum spanning tree cost block.
`timescale 1ns / 1ps
`default_nettype none
package mstc_pkg;
    localparam int MAX_NODES_DEF = 128;
    localparam int MAX_EDGES_DEF = 1024;
    localparam int COST_BITS_DEF = 16;
    localparam int NODE_W        = 7;
    localparam int CNT_W         = 8;
    localparam int TOTAL_W       = 23;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [CNT_W-1:0]   NODE_COUNT_RST = 8'd128;

    // Request from the sequencer to the union-find unit.
    typedef struct packed {
        logic             start;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } t_uf_req;

    // Answer from the union-find unit.
    typedef struct packed {
        logic done;
        logic joined;
    } t_uf_rsp;
endpackage
`default_nettype wire

@@ rtl/mstc_forest.sv @@
// Union-find forest with path compression; one parent read or write per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mstc_forest (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_clear,
    output logic                 o_clear_busy,
    input  mstc_pkg::t_uf_req    i_req,
    output mstc_pkg::t_uf_rsp    o_rsp
);
    localparam int MAX_NODES = mstc_pkg::MAX_NODES_DEF;
    localparam int NW = mstc_pkg::NODE_W;
    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_FA_RD, S_FA_CHK, S_CA_RD, S_CA_WR,
        S_FB_RD, S_FB_CHK, S_CB_RD, S_CB_WR, S_LINK
    } t_state;

    logic [NW-1:0] r_mem [MAX_NODES];
    t_state        r_state;
    logic [NW-1:0] r_node_a, r_node_b, r_walk, r_cur, r_root_a, r_root_b;
    logic [NW-1:0] r_rd;
    logic [NW:0]   r_clr;
    logic          r_done, r_joined;

    logic [NW-1:0] w_addr, w_data;
    logic          w_we;
    logic [NW-1:0] w_rd_addr;

    always_comb begin
        w_we = 1'b0;
        w_addr = r_cur;
        w_data = r_walk;
        case (r_state)
            S_CLR: begin
                w_we = 1'b1;
                w_addr = r_clr[NW-1:0];
                w_data = r_clr[NW-1:0];
            end
            S_CA_WR, S_CB_WR: begin
                w_we = (r_cur != r_walk);
                w_addr = r_cur;
                w_data = r_walk;
            end
            S_LINK: begin
                w_we = (r_root_a != r_walk);
                w_addr = (r_root_a < r_walk) ? r_walk : r_root_a;
                w_data = (r_root_a < r_walk) ? r_root_a : r_walk;
            end
            default: ;
        endcase
    end

    always_comb begin
        case (r_state)
            S_FA_RD, S_FA_CHK, S_FB_RD, S_FB_CHK: w_rd_addr = r_walk;
            default:                              w_rd_addr = r_cur;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    // Find walks to the root, then a second walk rewrites every link on the path.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_done   <= 1'b0;
            r_joined <= 1'b0;
        end else begin
            r_done <= (r_state == S_LINK);
            case (r_state)
                S_IDLE: begin
                    if (i_clear) begin
                        r_clr   <= '0;
                        r_state <= S_CLR;
                    end else if (i_req.start) begin
                        r_node_a <= i_req.node_a;
                        r_node_b <= i_req.node_b;
                        r_walk   <= i_req.node_a;
                        r_cur    <= i_req.node_a;
                        r_state  <= S_FA_RD;
                    end
                end
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (NW+1)'(MAX_NODES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_FA_RD: r_state <= S_FA_CHK;
                S_FA_CHK: begin
                    if (r_rd == r_walk) begin
                        r_root_a <= r_walk;
                        r_state  <= S_CA_RD;
                    end else begin
                        r_walk  <= r_rd;
                        r_state <= S_FA_RD;
                    end
                end
                S_CA_RD: r_state <= S_CA_WR;
                S_CA_WR: begin
                    if (r_cur == r_walk) begin
                        r_walk  <= r_node_b;
                        r_cur   <= r_node_b;
                        r_state <= S_FB_RD;
                    end else begin
                        r_cur   <= r_rd;
                        r_state <= S_CA_RD;
                    end
                end
                S_FB_RD: r_state <= S_FB_CHK;
                S_FB_CHK: begin
                    if (r_rd == r_walk) begin
                        r_root_b <= r_walk;
                        r_state  <= S_CB_RD;
                    end else begin
                        r_walk  <= r_rd;
                        r_state <= S_FB_RD;
                    end
                end
                S_CB_RD: r_state <= S_CB_WR;
                S_CB_WR: begin
                    if (r_cur == r_walk) begin
                        r_state <= S_LINK;
                    end else begin
                        r_cur   <= r_rd;
                        r_state <= S_CB_RD;
                    end
                end
                S_LINK: begin
                    r_joined <= (r_root_a != r_walk);
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_clear_busy = (r_state == S_CLR);
    assign o_rsp.done   = r_done;
    assign o_rsp.joined = r_joined;

    logic w_unused;
    assign w_unused = ^{r_root_b, i_req.node_a, i_req.node_b};
endmodule
`default_nettype wire

@@ rtl/minimum_spanning_tree_cost_top.sv @@
// Top level: edge store, insertion sort sequencer and Kruskal control.
// Edges load one per cycle while the block is ready; an edge with s_axis_tlast
// set starts the run, and the block holds s_axis_tready low until the one
// result has been taken. The E stored edges are then sorted in place by cost
// over the edge store, with the most shifting when edges arrive in falling
// cost order. The forest is then reset, and each sorted edge walks the parent
// links on the two paths to its roots. After reset the forest reset pass also
// runs before the first edge is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "minimum_spanning_tree_cost_top_macros.svh"
module minimum_spanning_tree_cost_top #(
    parameter int MAX_EDGES = mstc_pkg::MAX_EDGES_DEF,
    parameter int COST_BITS = mstc_pkg::COST_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // node_a [6:0], node_b [13:7], edge_cost above, zero fill to bytes
    input  wire  [((2*mstc_pkg::NODE_W+COST_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // total_cost [22:0], zero fill [23]
    output logic [23:0] m_axis_tdata,
    // input_error
    output logic        m_axis_tuser,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [7:0]  i_cfg_data
);
    localparam int MAX_NODES = mstc_pkg::MAX_NODES_DEF;
    localparam int NW  = mstc_pkg::NODE_W;
    localparam int EW  = 2*NW + COST_BITS;
    localparam int AW  = $clog2(MAX_EDGES);
    localparam int TW  = mstc_pkg::TOTAL_W;
    localparam int SW  = ((COST_BITS > TW) ? COST_BITS : TW) + 1;

    typedef enum logic [3:0] {
        S_LOAD, S_SORT_OUT, S_SORT_RD, S_SORT_CMP, S_SORT_WR, S_SORT_PUT,
        S_CLEAR, S_KR_RD, S_KR_WAIT, S_KR_UF, S_KR_ADD, S_OUT
    } t_state;

    logic [EW-1:0]  r_store [MAX_EDGES];
    logic [EW-1:0]  r_rd;
    t_state         r_state;
    logic [AW:0]    r_fill, r_i, r_j;
    logic [EW-1:0]  r_key;
    logic [TW-1:0]  r_total;
    logic           r_err;
    logic [7:0]     r_node_count;
    logic [COST_BITS-1:0] r_cost;
    mstc_pkg::t_uf_req r_req;
    mstc_pkg::t_uf_rsp w_rsp;
    logic           r_clear;
    logic           w_clear_busy;

    logic [NW-1:0]  w_a, w_b;
    logic [8:0]     w_limit;
    logic           w_bad, w_take;
    logic           w_we;
    logic [AW-1:0]  w_waddr, w_raddr;
    logic [EW-1:0]  w_wdata;
    logic [SW-1:0]  w_sum;

    assign w_a = s_axis_tdata[NW-1:0];
    assign w_b = s_axis_tdata[2*NW-1:NW];
    assign w_limit = ({1'b0, r_node_count} > 9'(MAX_NODES)) ? 9'(MAX_NODES)
                                                           : {1'b0, r_node_count};
    assign w_bad = ({2'b0, w_a} >= w_limit) || ({2'b0, w_b} >= w_limit)
                || (r_fill >= (AW+1)'(MAX_EDGES));
    assign w_take = s_axis_tvalid && s_axis_tready;

    // Compare holds the read of slot j-1; a shift reads slot j-2, which is
    // slot j-1 once j has stepped down.
    always_comb begin
        w_we = 1'b0;
        w_waddr = r_fill[AW-1:0];
        w_wdata = s_axis_tdata[EW-1:0];
        w_raddr = r_i[AW-1:0];
        case (r_state)
            S_LOAD: w_we = w_take && !w_bad;
            S_SORT_RD, S_SORT_CMP: w_raddr = r_j[AW-1:0] - 1'b1;
            S_SORT_WR: begin
                w_we = 1'b1;
                w_waddr = r_j[AW-1:0];
                w_wdata = r_rd;
                w_raddr = r_j[AW-1:0] - 2'd2;
            end
            S_SORT_PUT: begin
                w_we = 1'b1;
                w_waddr = r_j[AW-1:0];
                w_wdata = r_key;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_waddr] <= w_wdata;
        end
        r_rd <= r_store[w_raddr];
    end

    assign w_sum = SW'(r_total) + SW'(r_cost);

    // Load, insertion sort in place (larger costs shift up a slot), then Kruskal.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_fill       <= '0;
            r_total      <= '0;
            r_err        <= 1'b0;
            r_node_count <= mstc_pkg::NODE_COUNT_RST;
            r_req.start  <= 1'b0;
            r_clear      <= 1'b0;
        end else begin
            r_req.start <= (r_state == S_KR_WAIT);
            r_clear     <= (r_state == S_SORT_OUT) && (r_i >= r_fill);
            if (i_cfg_valid) begin
                r_node_count <= i_cfg_data;
            end
            case (r_state)
                S_LOAD: begin
                    if (w_take) begin
                        if (w_bad) begin
                            r_err <= 1'b1;
                        end
                        if (s_axis_tlast) begin
                            r_fill  <= r_fill + (AW+1)'(!w_bad);
                            r_i     <= (AW+1)'(1);
                            r_state <= S_SORT_OUT;
                        end else if (!w_bad) begin
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                end
                S_SORT_OUT: begin
                    if (r_i >= r_fill) begin
                        r_state <= S_CLEAR;
                    end else begin
                        r_j     <= r_i;
                        r_state <= S_SORT_RD;
                    end
                end
                S_SORT_RD: begin
                    r_key   <= r_rd;
                    r_state <= S_SORT_CMP;
                end
                S_SORT_CMP: begin
                    if (r_j != '0 && r_rd[EW-1:2*NW] > r_key[EW-1:2*NW]) begin
                        r_state <= S_SORT_WR;
                    end else begin
                        r_state <= S_SORT_PUT;
                    end
                end
                S_SORT_WR: begin
                    r_j     <= r_j - 1'b1;
                    r_state <= S_SORT_CMP;
                end
                S_SORT_PUT: begin
                    r_i     <= r_i + 1'b1;
                    r_state <= S_SORT_OUT;
                end
                S_CLEAR: begin
                    if (!r_clear && !w_clear_busy) begin
                        r_i     <= '0;
                        r_total <= '0;
                        r_state <= S_KR_RD;
                    end
                end
                S_KR_RD: begin
                    if (r_i >= r_fill) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_KR_WAIT;
                    end
                end
                S_KR_WAIT: begin
                    r_req.node_a <= r_rd[NW-1:0];
                    r_req.node_b <= r_rd[2*NW-1:NW];
                    r_cost       <= r_rd[EW-1:2*NW];
                    r_state      <= S_KR_UF;
                end
                S_KR_UF: begin
                    if (w_rsp.done) begin
                        r_state <= S_KR_ADD;
                    end
                end
                S_KR_ADD: begin
                    if (w_rsp.joined) begin
                        r_total <= (w_sum > SW'(mstc_pkg::TOTAL_MAX)) ? mstc_pkg::TOTAL_MAX
                                                                     : w_sum[TW-1:0];
                    end
                    r_i     <= r_i + 1'b1;
                    r_state <= S_KR_RD;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_fill  <= '0;
                        r_err   <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    mstc_forest u_forest (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (r_clear),
        .o_clear_busy (w_clear_busy),
        .i_req        (r_req),
        .o_rsp        (w_rsp)
    );

    assign s_axis_tready = (r_state == S_LOAD) && !w_clear_busy;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {1'b0, r_total};
    assign m_axis_tuser  = r_err;
    assign o_cfg_ready   = 1'b1;

    logic w_unused;
    assign w_unused = ^s_axis_tdata;

    `MSTC_ASSERT_IMP(a_out_only_idle_load, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "input taken while result pending")
    `MSTC_ASSERT_NEXT(a_fill_reset, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready, r_fill == '0 && !r_err, "state not cleared after result")
    `MSTC_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= (AW+1)'(MAX_EDGES), "edge fill beyond capacity")
endmodule
`default_nettype wire
